// ===== rtl/tile_to_quad_vertex_generator_macros.svh =====
`ifndef TILE_TO_QUAD_VERTEX_GENERATOR_MACROS_SVH
`define TILE_TO_QUAD_VERTEX_GENERATOR_MACROS_SVH

// same-cycle implication, clocked on aclk, off during reset
`define TTQV_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TTQV_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ttqv_pkg.sv =====
`timescale 1ns / 1ps

package ttqv_pkg;

    localparam int unsigned MAP_SIZE   = 4096;
    localparam int unsigned QUAD_VERTS = 6;

    localparam int COL_W   = 12;
    localparam int RAW_W   = 32;
    localparam int ID_W    = 29;
    localparam int WH_W    = 9;
    localparam int COLS_W  = 13;
    localparam int XY_W    = 21;
    localparam int TV_W    = 38;
    localparam int BEAT_W  = 3;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;

    localparam int DIV_STEPS = ID_W;

    localparam logic [RAW_W-1:0] ID_MASK = 32'h1FFF_FFFF;

    localparam logic [BEAT_W-1:0] LAST_BEAT = BEAT_W'(QUAD_VERTS - 1);

    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_ID_SET0    = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TILE_WIDTH_SET0  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TILE_HEIGHT_SET0 = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS_SET0     = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_ID_SET1    = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TILE_WIDTH_SET1  = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TILE_HEIGHT_SET1 = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS_SET1     = 4'd7;

    localparam logic [1:0] CORNER_TL = 2'd0;
    localparam logic [1:0] CORNER_TR = 2'd1;
    localparam logic [1:0] CORNER_BR = 2'd2;
    localparam logic [1:0] CORNER_BL = 2'd3;

    localparam logic [1:0] CORNER_OF_VERTEX [QUAD_VERTS] = '{
        CORNER_TL, CORNER_TR, CORNER_BR, CORNER_BR, CORNER_BL, CORNER_TL
    };

    typedef struct packed {
        logic right;
        logic bottom;
    } corner_flags_t;

    typedef struct packed {
        logic            sel;
        logic [XY_W-1:0] sx0;
        logic [XY_W-1:0] sy0;
    } side_t;

    typedef struct packed {
        logic            sel;
        logic [XY_W-1:0] sx0;
        logic [XY_W-1:0] sx1;
        logic [XY_W-1:0] sy0;
        logic [XY_W-1:0] sy1;
        logic [XY_W-1:0] tu0;
        logic [XY_W-1:0] tu1;
        logic [TV_W-1:0] tv0;
        logic [TV_W-1:0] tv1;
    } tile_t;

    function automatic corner_flags_t corner_flags(input logic [BEAT_W-1:0] beat);
        corner_flags_t f;
        logic [1:0]    c;
        c = (beat <= LAST_BEAT) ? CORNER_OF_VERTEX[beat] : CORNER_TL;
        f.right  = (c == CORNER_TR) || (c == CORNER_BR);
        f.bottom = (c == CORNER_BR) || (c == CORNER_BL);
        return f;
    endfunction

endpackage

// ===== rtl/ttqv_divider.sv =====
`timescale 1ns / 1ps

module ttqv_divider import ttqv_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [ID_W-1:0]   in_dividend,
    input  logic [COLS_W-1:0] in_divisor,
    input  side_t             in_side,
    output logic              out_valid,
    output logic [ID_W-1:0]   out_quot,
    output logic [COLS_W-1:0] out_rem,
    output side_t             out_side
);

    // one restoring step per stage, quotient shifts in behind the dividend
    logic              vld_reg  [DIV_STEPS];
    logic [ID_W-1:0]   work_reg [DIV_STEPS];
    logic [COLS_W-1:0] rem_reg  [DIV_STEPS];
    logic [COLS_W-1:0] dvs_reg  [DIV_STEPS];
    side_t             side_reg [DIV_STEPS];

    logic              vld_next  [DIV_STEPS];
    logic [ID_W-1:0]   work_next [DIV_STEPS];
    logic [COLS_W-1:0] rem_next  [DIV_STEPS];
    logic [COLS_W-1:0] dvs_next  [DIV_STEPS];
    side_t             side_next [DIV_STEPS];

    always_comb begin
        logic              v;
        logic [ID_W-1:0]   w;
        logic [COLS_W-1:0] r;
        logic [COLS_W-1:0] d;
        side_t             sd;
        logic [COLS_W:0]   trial;
        logic [COLS_W:0]   diff;
        logic              fits;
        for (int k = 0; k < DIV_STEPS; k++) begin
            if (k == 0) begin
                v  = in_valid;
                w  = in_dividend;
                r  = '0;
                d  = in_divisor;
                sd = in_side;
            end else begin
                v  = vld_reg[k-1];
                w  = work_reg[k-1];
                r  = rem_reg[k-1];
                d  = dvs_reg[k-1];
                sd = side_reg[k-1];
            end
            trial = {r, w[ID_W-1]};
            diff  = trial - {1'b0, d};
            fits  = trial >= {1'b0, d};
            vld_next[k]  = v;
            work_next[k] = {w[ID_W-2:0], fits};
            rem_next[k]  = fits ? diff[COLS_W-1:0] : trial[COLS_W-1:0];
            dvs_next[k]  = d;
            side_next[k] = sd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < DIV_STEPS; k++) begin
                vld_reg[k] <= 1'b0;
            end
        end else if (en) begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            work_reg <= work_next;
            rem_reg  <= rem_next;
            dvs_reg  <= dvs_next;
            side_reg <= side_next;
        end
    end

    assign out_valid = vld_reg[DIV_STEPS-1];
    assign out_quot  = work_reg[DIV_STEPS-1];
    assign out_rem   = rem_reg[DIV_STEPS-1];
    assign out_side  = side_reg[DIV_STEPS-1];

endmodule

// ===== rtl/ttqv_vertex_out.sv =====
`timescale 1ns / 1ps

module ttqv_vertex_out import ttqv_pkg::*; (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            tile_valid,
    output logic            tile_ready,
    input  tile_t           tile,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [XY_W-1:0] m_screen_x,
    output logic [XY_W-1:0] m_screen_y,
    output logic [XY_W-1:0] m_texel_u,
    output logic [TV_W-1:0] m_texel_v,
    output logic            m_tileset_sel,
    output logic            m_last_vertex
);

    logic              buf_valid_reg;
    logic [BEAT_W-1:0] vertex_beat_reg;
    logic [XY_W-1:0]   corner_left_reg, corner_right_reg;
    logic [XY_W-1:0]   corner_top_reg, corner_bottom_reg;
    logic [XY_W-1:0]   tex_left_reg, tex_right_reg;
    logic [TV_W-1:0]   tex_top_reg, tex_bottom_reg;
    logic              held_set_reg;

    logic              m_valid_reg;
    logic [XY_W-1:0]   m_screen_x_reg, m_screen_y_reg, m_texel_u_reg;
    logic [TV_W-1:0]   m_texel_v_reg;
    logic              m_tileset_sel_reg, m_last_vertex_reg;

    logic              out_load, buf_done, tile_take;
    corner_flags_t     flags;

    assign out_load   = buf_valid_reg && (!m_valid_reg || m_ready);
    assign buf_done   = out_load && (vertex_beat_reg == LAST_BEAT);
    assign tile_ready = !buf_valid_reg || buf_done;
    assign tile_take  = tile_valid && tile_ready;
    assign flags      = corner_flags(vertex_beat_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buf_valid_reg   <= 1'b0;
            vertex_beat_reg <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (tile_take) begin
                buf_valid_reg <= 1'b1;
            end else if (buf_done) begin
                buf_valid_reg <= 1'b0;
            end
            if (out_load) begin
                vertex_beat_reg <= buf_done ? '0 : vertex_beat_reg + 1'b1;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (tile_take) begin
            corner_left_reg   <= tile.sx0;
            corner_right_reg  <= tile.sx1;
            corner_top_reg    <= tile.sy0;
            corner_bottom_reg <= tile.sy1;
            tex_left_reg      <= tile.tu0;
            tex_right_reg     <= tile.tu1;
            tex_top_reg       <= tile.tv0;
            tex_bottom_reg    <= tile.tv1;
            held_set_reg      <= tile.sel;
        end
        if (out_load) begin
            m_screen_x_reg    <= flags.right  ? corner_right_reg  : corner_left_reg;
            m_screen_y_reg    <= flags.bottom ? corner_bottom_reg : corner_top_reg;
            m_texel_u_reg     <= flags.right  ? tex_right_reg     : tex_left_reg;
            m_texel_v_reg     <= flags.bottom ? tex_bottom_reg    : tex_top_reg;
            m_tileset_sel_reg <= held_set_reg;
            m_last_vertex_reg <= (vertex_beat_reg == LAST_BEAT);
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_screen_x    = m_screen_x_reg;
    assign m_screen_y    = m_screen_y_reg;
    assign m_texel_u     = m_texel_u_reg;
    assign m_texel_v     = m_texel_v_reg;
    assign m_tileset_sel = m_tileset_sel_reg;
    assign m_last_vertex = m_last_vertex_reg;

endmodule

// ===== rtl/tile_to_quad_vertex_generator.sv =====
`timescale 1ns / 1ps

// Turns map tiles into textured quads: each tile transaction that has a nonzero id (flip
// flags ignored) and falls in a configured tileset comes out as six vertices, two triangles
// over corners TL,TR,BR,BR,BL,TL, the sixth flagged last_vertex; other tiles are dropped.
// A tile is accepted in any cycle the pipeline is not held; the output stage sends one
// vertex per cycle while m_ready is high and takes the next tile as the last vertex of the
// one before is loaded, so the sustained tile rate is set by that stage. A tile passes
// through two front stages, a 29-stage restoring divider for the texture column and row,
// two multiply/add stages, the vertex buffer and the output register.
// Register writes are taken every cycle; an unknown index is ignored.

`include "tile_to_quad_vertex_generator_macros.svh"

module tile_to_quad_vertex_generator import ttqv_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [COL_W-1:0]      s_map_col,
    input  logic [COL_W-1:0]      s_map_row,
    input  logic [RAW_W-1:0]      s_raw_tile_id,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [XY_W-1:0]       m_screen_x,
    output logic [XY_W-1:0]       m_screen_y,
    output logic [XY_W-1:0]       m_texel_u,
    output logic [TV_W-1:0]       m_texel_v,
    output logic                  m_tileset_sel,
    output logic                  m_last_vertex
);

    logic [ID_W-1:0]   first_id_set0_reg, first_id_set1_reg;
    logic [WH_W-1:0]   tile_width_set0_reg, tile_width_set1_reg;
    logic [WH_W-1:0]   tile_height_set0_reg, tile_height_set1_reg;
    logic [COLS_W-1:0] columns_set0_reg, columns_set1_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_id_set0_reg    <= ID_W'(1);
            tile_width_set0_reg  <= WH_W'(16);
            tile_height_set0_reg <= WH_W'(16);
            columns_set0_reg     <= COLS_W'(16);
            first_id_set1_reg    <= ID_W'(536870911);
            tile_width_set1_reg  <= WH_W'(16);
            tile_height_set1_reg <= WH_W'(16);
            columns_set1_reg     <= COLS_W'(16);
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_FIRST_ID_SET0:    first_id_set0_reg    <= cfg_data[ID_W-1:0];
                CFG_TILE_WIDTH_SET0:  tile_width_set0_reg  <= cfg_data[WH_W-1:0];
                CFG_TILE_HEIGHT_SET0: tile_height_set0_reg <= cfg_data[WH_W-1:0];
                CFG_COLUMNS_SET0:     columns_set0_reg     <= cfg_data[COLS_W-1:0];
                CFG_FIRST_ID_SET1:    first_id_set1_reg    <= cfg_data[ID_W-1:0];
                CFG_TILE_WIDTH_SET1:  tile_width_set1_reg  <= cfg_data[WH_W-1:0];
                CFG_TILE_HEIGHT_SET1: tile_height_set1_reg <= cfg_data[WH_W-1:0];
                CFG_COLUMNS_SET1:     columns_set1_reg     <= cfg_data[COLS_W-1:0];
                default: ;
            endcase
        end
    end

    // whole pipe moves together; held only when its last stage cannot hand over
    logic  advance;
    logic  tile_ready;
    logic  m2_valid_reg;
    tile_t m2_tile_reg;

    assign advance = !m2_valid_reg || tile_ready;
    assign s_ready = advance;

    // stage 1: flag strip, range checks, tileset compares
    logic [RAW_W-1:0] raw_masked;
    logic [ID_W-1:0]  id_in;
    logic             in_map;
    logic             s1_valid_reg, s1_ge0_reg, s1_ge1_reg;
    logic [COL_W-1:0] s1_col_reg, s1_row_reg;
    logic [ID_W-1:0]  s1_id_reg;

    assign raw_masked = s_raw_tile_id & ID_MASK;
    assign id_in      = raw_masked[ID_W-1:0];
    assign in_map     = (32'(s_map_col) < MAP_SIZE) && (32'(s_map_row) < MAP_SIZE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (advance) begin
            s1_valid_reg <= s_valid && (id_in != '0) && in_map;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            s1_col_reg <= s_map_col;
            s1_row_reg <= s_map_row;
            s1_id_reg  <= id_in;
            s1_ge1_reg <= id_in >= first_id_set1_reg;
            s1_ge0_reg <= id_in >= first_id_set0_reg;
        end
    end

    // stage 2: local id, divisor, screen top-left
    logic                   s2_sel;
    logic [ID_W-1:0]        s2_first;
    logic [WH_W-1:0]        s2_w, s2_h;
    logic [COLS_W-1:0]      s2_cols_raw;
    logic [COL_W+WH_W-1:0]  s2_sx_prod, s2_sy_prod;
    logic                   s2_valid_reg;
    logic [ID_W-1:0]        s2_local_reg;
    logic [COLS_W-1:0]      s2_cols_reg;
    side_t                  s2_side_reg;

    assign s2_sel      = s1_ge1_reg;
    assign s2_first    = s2_sel ? first_id_set1_reg    : first_id_set0_reg;
    assign s2_w        = s2_sel ? tile_width_set1_reg  : tile_width_set0_reg;
    assign s2_h        = s2_sel ? tile_height_set1_reg : tile_height_set0_reg;
    assign s2_cols_raw = s2_sel ? columns_set1_reg     : columns_set0_reg;
    assign s2_sx_prod  = s1_col_reg * s2_w;
    assign s2_sy_prod  = s1_row_reg * s2_h;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (advance) begin
            s2_valid_reg <= s1_valid_reg && (s1_ge1_reg || s1_ge0_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            s2_local_reg    <= s1_id_reg - s2_first;
            s2_cols_reg     <= (s2_cols_raw == '0) ? COLS_W'(1) : s2_cols_raw;
            s2_side_reg.sel <= s2_sel;
            s2_side_reg.sx0 <= s2_sx_prod[XY_W-1:0];
            s2_side_reg.sy0 <= s2_sy_prod[XY_W-1:0];
        end
    end

    logic              div_valid;
    logic [ID_W-1:0]   div_quot;
    logic [COLS_W-1:0] div_rem;
    side_t             div_side;

    ttqv_divider u_divider (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (advance),
        .in_valid    (s2_valid_reg),
        .in_dividend (s2_local_reg),
        .in_divisor  (s2_cols_reg),
        .in_side     (s2_side_reg),
        .out_valid   (div_valid),
        .out_quot    (div_quot),
        .out_rem     (div_rem),
        .out_side    (div_side)
    );

    // stage M1: texture top-left products, screen far corners
    logic [WH_W-1:0]        m1_w_in, m1_h_in;
    logic [COLS_W+WH_W-1:0] m1_tu_prod;
    logic [ID_W+WH_W-1:0]   m1_tv_prod;
    logic                   m1_valid_reg;
    tile_t                  m1_tile_reg;

    assign m1_w_in    = div_side.sel ? tile_width_set1_reg  : tile_width_set0_reg;
    assign m1_h_in    = div_side.sel ? tile_height_set1_reg : tile_height_set0_reg;
    assign m1_tu_prod = div_rem * m1_w_in;
    assign m1_tv_prod = div_quot * m1_h_in;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m1_valid_reg <= 1'b0;
        end else if (advance) begin
            m1_valid_reg <= div_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m1_tile_reg.sel <= div_side.sel;
            m1_tile_reg.sx0 <= div_side.sx0;
            m1_tile_reg.sx1 <= div_side.sx0 + XY_W'(m1_w_in);
            m1_tile_reg.sy0 <= div_side.sy0;
            m1_tile_reg.sy1 <= div_side.sy0 + XY_W'(m1_h_in);
            m1_tile_reg.tu0 <= m1_tu_prod[XY_W-1:0];
            m1_tile_reg.tu1 <= '0;
            m1_tile_reg.tv0 <= m1_tv_prod[TV_W-1:0];
            m1_tile_reg.tv1 <= '0;
        end
    end

    // stage M2: texture far corners
    logic [WH_W-1:0] m2_w_in, m2_h_in;

    assign m2_w_in = m1_tile_reg.sel ? tile_width_set1_reg  : tile_width_set0_reg;
    assign m2_h_in = m1_tile_reg.sel ? tile_height_set1_reg : tile_height_set0_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m2_valid_reg <= 1'b0;
        end else if (advance) begin
            m2_valid_reg <= m1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m2_tile_reg.sel <= m1_tile_reg.sel;
            m2_tile_reg.sx0 <= m1_tile_reg.sx0;
            m2_tile_reg.sx1 <= m1_tile_reg.sx1;
            m2_tile_reg.sy0 <= m1_tile_reg.sy0;
            m2_tile_reg.sy1 <= m1_tile_reg.sy1;
            m2_tile_reg.tu0 <= m1_tile_reg.tu0;
            m2_tile_reg.tu1 <= m1_tile_reg.tu0 + XY_W'(m2_w_in);
            m2_tile_reg.tv0 <= m1_tile_reg.tv0;
            m2_tile_reg.tv1 <= m1_tile_reg.tv0 + TV_W'(m2_h_in);
        end
    end

    ttqv_vertex_out u_vertex_out (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .tile_valid    (m2_valid_reg),
        .tile_ready    (tile_ready),
        .tile          (m2_tile_reg),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_screen_x    (m_screen_x),
        .m_screen_y    (m_screen_y),
        .m_texel_u     (m_texel_u),
        .m_texel_v     (m_texel_v),
        .m_tileset_sel (m_tileset_sel),
        .m_last_vertex (m_last_vertex)
    );

    `TTQV_ASSERT_NEXT(a_tile_continues, m_valid && m_ready && !m_last_vertex, m_valid && (m_tileset_sel == $past(m_tileset_sel)), "vertex run of a tile broken")
    `TTQV_ASSERT_NEXT(a_pipe_end_holds, m2_valid_reg && !tile_ready, m2_valid_reg && $stable(m2_tile_reg), "held tile lost at pipe end")
    `TTQV_ASSERT_IMPL(a_free_when_empty, !m2_valid_reg, s_ready, "pipe stalled with empty last stage")

endmodule

// ===== tb/tile_to_quad_vertex_generator_tb.sv =====
`timescale 1ns / 1ps

module tile_to_quad_vertex_generator_tb;
    import ttqv_pkg::*;

    localparam int NUM_REGS       = 8;
    localparam int DRAIN_CYCLES   = 64;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_PHASES  = 4;
    localparam int TILES_PER_PHASE = 72;

    typedef struct {
        logic [COL_W-1:0] col;
        logic [COL_W-1:0] row;
        logic [RAW_W-1:0] raw;
        logic             hold;
    } map_tile_t;

    typedef struct packed {
        logic [XY_W-1:0] sx;
        logic [XY_W-1:0] sy;
        logic [XY_W-1:0] tu;
        logic [TV_W-1:0] tv;
        logic            sel;
        logic            last;
    } vertex_t;

    typedef struct {
        logic [ID_W-1:0]   first_id;
        logic [WH_W-1:0]   width;
        logic [WH_W-1:0]   height;
        logic [COLS_W-1:0] columns;
    } tileset_regs_t;

    logic                  aclk;
    logic                  aresetn       = 1'b0;
    logic                  cfg_valid     = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_data      = '0;
    logic                  s_valid       = 1'b0;
    logic                  s_ready;
    logic [COL_W-1:0]      s_map_col     = '0;
    logic [COL_W-1:0]      s_map_row     = '0;
    logic [RAW_W-1:0]      s_raw_tile_id = '0;
    logic                  m_valid;
    logic                  m_ready       = 1'b0;
    logic [XY_W-1:0]       m_screen_x;
    logic [XY_W-1:0]       m_screen_y;
    logic [XY_W-1:0]       m_texel_u;
    logic [TV_W-1:0]       m_texel_v;
    logic                  m_tileset_sel;
    logic                  m_last_vertex;

    map_tile_t     tile_q[$];
    vertex_t       vertex_q[$];
    tileset_regs_t sets[2];
    map_tile_t     next_tile;
    int            send_idle_pct = 0;
    int            recv_stall_pct = 0;
    int            mismatches = 0;
    int            quiet_cycles = 0;
    logic          results_idle = 1'b1;

    tile_to_quad_vertex_generator dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_map_col     (s_map_col),
        .s_map_row     (s_map_row),
        .s_raw_tile_id (s_raw_tile_id),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_screen_x    (m_screen_x),
        .m_screen_y    (m_screen_y),
        .m_texel_u     (m_texel_u),
        .m_texel_v     (m_texel_v),
        .m_tileset_sel (m_tileset_sel),
        .m_last_vertex (m_last_vertex)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_FIRST_ID_SET0:    sets[0].first_id = data[ID_W-1:0];
            CFG_TILE_WIDTH_SET0:  sets[0].width    = data[WH_W-1:0];
            CFG_TILE_HEIGHT_SET0: sets[0].height   = data[WH_W-1:0];
            CFG_COLUMNS_SET0:     sets[0].columns  = data[COLS_W-1:0];
            CFG_FIRST_ID_SET1:    sets[1].first_id = data[ID_W-1:0];
            CFG_TILE_WIDTH_SET1:  sets[1].width    = data[WH_W-1:0];
            CFG_TILE_HEIGHT_SET1: sets[1].height   = data[WH_W-1:0];
            CFG_COLUMNS_SET1:     sets[1].columns  = data[COLS_W-1:0];
            default: ;
        endcase
    endfunction

    // six vertices per drawable tile, corners TL,TR,BR,BR,BL,TL
    function automatic void queue_quad(input logic [COL_W-1:0] col, input logic [COL_W-1:0] row,
                                       input logic [RAW_W-1:0] raw);
        logic [ID_W-1:0] id;
        int              sel;
        logic [63:0]     c, r, wd, ht, nc, loc, tc, tr;
        logic [XY_W-1:0] sx[2], sy[2], tu[2];
        logic [TV_W-1:0] tv[2];
        logic [63:0]     prod;
        logic [1:0]      corner;
        logic            right, bottom;
        vertex_t         v;
        id = ID_W'(raw & ID_MASK);
        if (id == 0 || col >= MAP_SIZE || row >= MAP_SIZE)
            return;
        if (id >= sets[1].first_id)
            sel = 1;
        else if (id >= sets[0].first_id)
            sel = 0;
        else
            return;
        c   = 64'(col);
        r   = 64'(row);
        wd  = 64'(sets[sel].width);
        ht  = 64'(sets[sel].height);
        nc  = (sets[sel].columns == 0) ? 64'd1 : 64'(sets[sel].columns);
        loc = 64'(id - sets[sel].first_id);
        tc  = loc % nc;
        tr  = loc / nc;
        prod = c * wd;        sx[0] = prod[XY_W-1:0];
        prod = (c + 1) * wd;  sx[1] = prod[XY_W-1:0];
        prod = r * ht;        sy[0] = prod[XY_W-1:0];
        prod = (r + 1) * ht;  sy[1] = prod[XY_W-1:0];
        prod = tc * wd;       tu[0] = prod[XY_W-1:0];
        prod = (tc + 1) * wd; tu[1] = prod[XY_W-1:0];
        prod = tr * ht;       tv[0] = prod[TV_W-1:0];
        prod = (tr + 1) * ht; tv[1] = prod[TV_W-1:0];
        for (int k = 0; k < QUAD_VERTS; k++) begin
            corner = CORNER_OF_VERTEX[k];
            right  = (corner == CORNER_TR) || (corner == CORNER_BR);
            bottom = (corner == CORNER_BR) || (corner == CORNER_BL);
            v.sx   = sx[right];
            v.sy   = sy[bottom];
            v.tu   = tu[right];
            v.tv   = tv[bottom];
            v.sel  = 1'(sel);
            v.last = (k == QUAD_VERTS - 1);
            vertex_q = {vertex_q, v};
        end
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (tile_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct &&
                !(tile_q[0].hold && (s_valid || !results_idle))) begin
                next_tile = tile_q.pop_front();
                s_valid       <= 1'b1;
                s_map_col     <= next_tile.col;
                s_map_row     <= next_tile.row;
                s_raw_tile_id <= next_tile.raw;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn)
            m_ready <= 1'b0;
        else
            m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // monitor and scoreboard
    always @(posedge aclk) begin
        vertex_t want;
        if (!aresetn) begin
            sets[0] = '{29'd1, 9'd16, 9'd16, 13'd16};
            sets[1] = '{29'h1FFF_FFFF, 9'd16, 9'd16, 13'd16};
            quiet_cycles <= 0;
            results_idle <= 1'b1;
        end else begin
            if (cfg_valid && cfg_ready)
                apply_reg(cfg_index, cfg_data);
            if (s_valid && s_ready)
                queue_quad(s_map_col, s_map_row, s_raw_tile_id);
            if (m_valid && m_ready) begin
                if (vertex_q.size() == 0) begin
                    $error("vertex transaction with nothing expected");
                    mismatches++;
                end else begin
                    want = vertex_q.pop_front();
                    check_field("screen_x", want.sx, m_screen_x);
                    check_field("screen_y", want.sy, m_screen_y);
                    check_field("texel_u", want.tu, m_texel_u);
                    check_field("texel_v", want.tv, m_texel_v);
                    check_field("tileset_sel", want.sel, m_tileset_sel);
                    check_field("last_vertex", want.last, m_last_vertex);
                end
            end
            results_idle <= (vertex_q.size() == 0);
            if ((cfg_valid && cfg_ready) || (s_valid && s_ready) || (m_valid && m_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("simulation failed");
        $finish;
    end

    function automatic logic [CFG_DATA_W-1:0] with_junk(input logic [CFG_DATA_W-1:0] field,
                                                        input int width);
        return ($urandom << width) | field;
    endfunction

    function automatic void add_tile(input logic [COL_W-1:0] col, input logic [COL_W-1:0] row,
                                     input logic [RAW_W-1:0] raw, input logic hold = 1'b0);
        map_tile_t t;
        t = '{col, row, raw, hold};
        tile_q = {tile_q, t};
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk);
        while (!cfg_ready);
    endtask

    task automatic set_regs(input logic [ID_W-1:0] f0, input logic [WH_W-1:0] w0,
                            input logic [WH_W-1:0] h0, input logic [COLS_W-1:0] c0,
                            input logic [ID_W-1:0] f1, input logic [WH_W-1:0] w1,
                            input logic [WH_W-1:0] h1, input logic [COLS_W-1:0] c1);
        @(posedge aclk);
        write_reg(CFG_IDX_W'($urandom_range(NUM_REGS, 2**CFG_IDX_W - 1)), $urandom);
        write_reg(CFG_FIRST_ID_SET0,    with_junk(f0, ID_W));
        write_reg(CFG_TILE_WIDTH_SET0,  with_junk(w0, WH_W));
        write_reg(CFG_TILE_HEIGHT_SET0, with_junk(h0, WH_W));
        write_reg(CFG_COLUMNS_SET0,     with_junk(c0, COLS_W));
        write_reg(CFG_FIRST_ID_SET1,    with_junk(f1, ID_W));
        write_reg(CFG_TILE_WIDTH_SET1,  with_junk(w1, WH_W));
        write_reg(CFG_TILE_HEIGHT_SET1, with_junk(h1, WH_W));
        write_reg(CFG_COLUMNS_SET1,     with_junk(c1, COLS_W));
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    // wait for all tiles to go in and all vertices to come out, then let the pipe empty
    task automatic settle();
        do @(negedge aclk);
        while (tile_q.size() != 0 || s_valid || vertex_q.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    function automatic logic [ID_W-1:0] rand_first();
        case ($urandom_range(0, 5))
            0:       return 1;
            1:       return 0;
            2:       return '1;
            3:       return ID_W'($urandom);
            default: return ID_W'($urandom_range(1, 500));
        endcase
    endfunction

    function automatic logic [WH_W-1:0] rand_size();
        case ($urandom_range(0, 6))
            0:       return 0;
            1:       return 1;
            2:       return 256;
            3:       return '1;
            4:       return WH_W'($urandom_range(0, 511));
            default: return WH_W'($urandom_range(1, 32));
        endcase
    endfunction

    function automatic logic [COLS_W-1:0] rand_cols();
        case ($urandom_range(0, 6))
            0:       return 0;
            1:       return 1;
            2:       return 4096;
            3:       return '1;
            4:       return COLS_W'($urandom_range(0, 8191));
            default: return COLS_W'($urandom_range(1, 64));
        endcase
    endfunction

    function automatic logic [COL_W-1:0] rand_coord();
        case ($urandom_range(0, 7))
            0:       return 0;
            1:       return '1;
            default: return COL_W'($urandom_range(0, 4095));
        endcase
    endfunction

    task automatic random_settings();
        logic [ID_W-1:0] f0, f1;
        f0 = rand_first();
        case ($urandom_range(0, 3))
            0:       f1 = ID_W'($urandom);
            1:       f1 = f0 - ID_W'($urandom_range(0, 50));
            default: f1 = f0 + ID_W'($urandom_range(1, 2000));
        endcase
        set_regs(f0, rand_size(), rand_size(), rand_cols(),
                 f1, rand_size(), rand_size(), rand_cols());
    endtask

    function automatic void add_random_tiles(input int count);
        logic [ID_W-1:0] id;
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(0, 9))
                0:       id = 0;
                1:       id = ID_W'($urandom);
                2:       id = sets[0].first_id - ID_W'($urandom_range(1, 4));
                3, 4, 5: id = sets[0].first_id + ID_W'($urandom_range(0, 300));
                6, 7, 8: id = sets[1].first_id + ID_W'($urandom_range(0, 300));
                default: id = '1 - ID_W'($urandom_range(0, 3));
            endcase
            add_tile(rand_coord(), rand_coord(), {3'($urandom_range(0, 7)), id},
                     $urandom_range(0, 49) == 0);
        end
    endfunction

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset settings
        add_tile(0, 0, 32'h0000_0000);
        add_tile(5, 5, 32'hE000_0000);
        add_tile(0, 0, 32'h0000_0001);
        add_tile(4095, 4095, 32'h1FFF_FFFE);
        add_tile(4095, 0, 32'hFFFF_FFFF);
        add_tile(0, 4095, 32'h2000_0011);
        add_tile(7, 3, 32'h4000_0123, 1'b1);
        add_tile(12'hAAA, 12'h555, 32'h8ABC_DEF0);
        settle();

        // zero width, zero columns, widest tiles and column counts
        set_regs(29'd1, 9'd0, 9'd511, 13'd0, 29'h1000, 9'd511, 9'd1, 13'd8191);
        add_tile(100, 200, 32'h0000_0FFF);
        add_tile(4095, 4095, 32'h1FFF_FFFF);
        add_tile(1, 1, 32'h0000_1000);
        add_tile(2, 2, 32'hC000_0FFF);
        add_tile(12'h555, 12'hAAA, 32'h1FFF_0000);
        settle();

        // ids below both tilesets, a texture row near the top of the texel_v range
        set_regs(29'd100, 9'd256, 9'd511, 13'd1, 29'h1FFF_FFFF, 9'd1, 9'd256, 13'd4096);
        add_tile(3, 4, 32'h0000_0032);
        add_tile(3, 4, 32'h0000_0063);
        add_tile(9, 9, 32'h0000_0064);
        add_tile(4095, 4095, 32'h1FFF_FFFE);
        add_tile(0, 0, 32'h3FFF_FFFF);
        add_tile(4095, 4095, 32'hBFFF_FFFE);
        settle();

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 80; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 80; end
                default: begin send_idle_pct = 29; recv_stall_pct = 29; end
            endcase
            random_settings();
            add_random_tiles(TILES_PER_PHASE);
            settle();
        end

        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
